>>> sv/htfp_pkg.sv
// Shared types and constants for the header/tail frame parser.
// No dependencies; every other file of the block except htfp_ram uses this package.
package htfp_pkg;

    localparam int BYTE_W    = 8;
    localparam int HDR_W     = 24;
    localparam int HDR_LEN   = 3;
    localparam int POS_W     = 2;
    localparam int CFG_IDX_W = 1;
    localparam int STATUS_W  = 3;

    // Reset values of the configuration registers.
    localparam logic [HDR_W-1:0]  HDR_RESET  = 24'h686620;
    localparam logic [BYTE_W-1:0] TAIL_RESET = 8'h3B;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_HEADER = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TAIL   = 1'b1;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_PROGRESS   = 3'd0,
        ST_OK         = 3'd1,
        ST_UNDETECTED = 3'd2,
        ST_SYNC_FAIL  = 3'd3,
        ST_OVERFLOW   = 3'd4
    } status_t;

endpackage

>>> sv/htfp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module htfp_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wen,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (wen) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> sv/htfp_front.sv
// Front end of the frame parser: configuration registers, header hunt,
// frame storage writes and one command per accepted byte. Uses htfp_pkg.
module htfp_front #(
    parameter int MSG_MAX = 64,
    parameter int CNT_W   = $clog2(MSG_MAX + 1),
    parameter int ADDR_W  = $clog2(MSG_MAX)
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [htfp_pkg::BYTE_W-1:0]         s_in_byte,
    input  logic                                cfg_wen,
    input  logic [htfp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [htfp_pkg::HDR_W-1:0]          cfg_wdata,
    input  logic                                q_full,
    output logic                                q_push,
    output htfp_pkg::status_t                   q_status,
    input  logic                                frame_done,
    output logic [CNT_W-1:0]                    frame_len,
    output logic                                mem_wen,
    output logic [ADDR_W-1:0]                   mem_waddr,
    output logic [htfp_pkg::BYTE_W-1:0]         mem_wdata
);

    import htfp_pkg::*;

    typedef enum logic [1:0] {
        P_IDLE = 2'd0,
        P_HDR  = 2'd1,
        P_PAYL = 2'd2
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [CNT_W-1:0]    len_reg, len_next;
    logic                pend_reg, pend_next;
    logic [HDR_W-1:0]    header_reg;
    logic [BYTE_W-1:0]   tail_reg;
    logic                accept;
    logic [CNT_W-1:0]    cnt_inc;
    logic [BYTE_W-1:0]   hdr_sel;

    // Input is held off while a finished frame is still being read back.
    assign s_ready   = !pend_reg && !q_full;
    assign accept    = s_valid && s_ready;
    assign cnt_inc   = cnt_reg + 1'b1;
    assign frame_len = len_reg;
    assign mem_wdata = s_in_byte;

    // Expected header byte at the current header position.
    always_comb begin
        unique case (pos_reg)
            2'd1:    hdr_sel = header_reg[15:8];
            2'd2:    hdr_sel = header_reg[7:0];
            default: hdr_sel = header_reg[23:16];
        endcase
    end

    // Byte classification and next-state logic.
    always_comb begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        pos_next   = pos_reg;
        len_next   = len_reg;
        pend_next  = pend_reg;
        mem_wen    = 1'b0;
        mem_waddr  = cnt_reg[ADDR_W-1:0];
        q_push     = accept;
        q_status   = ST_PROGRESS;
        if (frame_done) begin
            pend_next = 1'b0;
        end
        if (accept) begin
            unique case (phase_reg)
                P_HDR: begin
                    if (pos_reg != POS_W'(HDR_LEN) && s_in_byte == hdr_sel) begin
                        mem_wen  = 1'b1;
                        cnt_next = cnt_inc;
                        pos_next = pos_reg + 1'b1;
                        if (pos_reg == POS_W'(HDR_LEN - 1)) begin
                            phase_next = P_PAYL;
                        end
                    end else begin
                        phase_next = P_IDLE;
                        cnt_next   = '0;
                        pos_next   = '0;
                        q_status   = ST_SYNC_FAIL;
                    end
                end
                P_PAYL: begin
                    mem_wen = (cnt_reg < CNT_W'(MSG_MAX));
                    if (s_in_byte == tail_reg) begin
                        len_next   = cnt_inc;
                        pend_next  = 1'b1;
                        phase_next = P_IDLE;
                        cnt_next   = '0;
                        pos_next   = '0;
                        q_status   = ST_OK;
                    end else if (cnt_inc >= CNT_W'(MSG_MAX)) begin
                        phase_next = P_IDLE;
                        cnt_next   = '0;
                        pos_next   = '0;
                        q_status   = ST_OVERFLOW;
                    end else begin
                        cnt_next = cnt_inc;
                    end
                end
                default: begin
                    // Idle, and the unused phase code, hunt for the first header byte.
                    if (s_in_byte == header_reg[23:16]) begin
                        phase_next = P_HDR;
                        mem_wen    = 1'b1;
                        mem_waddr  = '0;
                        cnt_next   = CNT_W'(1);
                        pos_next   = POS_W'(1);
                    end else begin
                        phase_next = P_IDLE;
                        cnt_next   = '0;
                        pos_next   = '0;
                        q_status   = ST_UNDETECTED;
                    end
                end
            endcase
        end
    end

    // State, configuration and frame length registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= P_IDLE;
            cnt_reg    <= '0;
            pos_reg    <= '0;
            pend_reg   <= 1'b0;
            header_reg <= HDR_RESET;
            tail_reg   <= TAIL_RESET;
        end else begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            pos_reg   <= pos_next;
            pend_reg  <= pend_next;
            if (cfg_wen && cfg_index == REG_HEADER) begin
                header_reg <= cfg_wdata;
            end
            if (cfg_wen && cfg_index == REG_TAIL) begin
                tail_reg <= cfg_wdata[BYTE_W-1:0];
            end
        end
        len_reg <= len_next;
    end

`ifndef SYNTHESIS
    // While hunting the header only positions one and two are possible.
    a_hdr_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == P_HDR |-> (pos_reg == 2'd1 || pos_reg == 2'd2))
        else $error("header position out of range");

    // In the payload phase the header is stored and the store is not full.
    a_payl_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == P_PAYL |-> (cnt_reg >= CNT_W'(HDR_LEN) && cnt_reg < CNT_W'(MSG_MAX)))
        else $error("stored count out of range in payload phase");

    // A pending frame is only ever left behind with the parser back in idle.
    a_pend_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> (phase_reg == P_IDLE && cnt_reg == '0))
        else $error("frame pending while parser is not idle");
`endif

endmodule

>>> sv/htfp_cmdq.sv
// Two-entry command queue between the parser front and back ends.
// Uses htfp_pkg for the status type.
module htfp_cmdq (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  htfp_pkg::status_t push_status,
    input  logic              pop,
    output logic              empty,
    output logic              full,
    output htfp_pkg::status_t head_status
);

    import htfp_pkg::*;

    status_t     entry [2];
    logic [1:0]  count_reg;
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;

    assign empty       = (count_reg == 2'd0);
    assign full        = (count_reg == 2'd2);
    assign head_status = entry[rd_ptr_reg];

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            entry[wr_ptr_reg] <= push_status;
        end
    end

`ifndef SYNTHESIS
    // The front end never pushes into a full queue.
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("command pushed into full queue");

    // The back end never pops an empty queue.
    a_no_underrun: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !empty)
        else $error("command popped from empty queue");
`endif

endmodule

>>> sv/htfp_back.sv
// Back end of the frame parser: takes commands from the queue and drives
// the result channel, reading a finished frame back from the store. Uses htfp_pkg.
module htfp_back #(
    parameter int MSG_MAX = 64,
    parameter int CNT_W   = $clog2(MSG_MAX + 1),
    parameter int ADDR_W  = $clog2(MSG_MAX)
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        q_empty,
    output logic                        q_pop,
    input  htfp_pkg::status_t           q_status,
    input  logic [CNT_W-1:0]            frame_len,
    output logic                        frame_done,
    output logic [ADDR_W-1:0]           rd_addr,
    input  logic [htfp_pkg::BYTE_W-1:0] rd_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [htfp_pkg::STATUS_W-1:0] m_status,
    output logic [htfp_pkg::BYTE_W-1:0] m_frame_byte,
    output logic                        m_last
);

    import htfp_pkg::*;

    typedef enum logic {
        B_IDLE = 1'b0,
        B_EMIT = 1'b1
    } bstate_t;

    bstate_t            state_reg, state_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [CNT_W-1:0]   idx_inc;
    logic               valid_reg, valid_next;
    status_t            status_reg, status_next;
    logic [BYTE_W-1:0]  byte_reg, byte_next;
    logic               last_reg, last_next;
    logic               out_free;
    logic               is_last;

    assign out_free     = !valid_reg || m_ready;
    assign idx_inc      = idx_reg + 1'b1;
    assign is_last      = (idx_inc == frame_len);
    assign m_valid      = valid_reg;
    assign m_status     = status_reg;
    assign m_frame_byte = byte_reg;
    assign m_last       = last_reg;

    // Command execution; the store is read one address ahead of the output.
    always_comb begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        valid_next  = valid_reg && !m_ready;
        status_next = status_reg;
        byte_next   = byte_reg;
        last_next   = last_reg;
        q_pop       = 1'b0;
        frame_done  = 1'b0;
        rd_addr     = idx_reg[ADDR_W-1:0];
        unique case (state_reg)
            B_IDLE: begin
                rd_addr = '0;
                if (!q_empty && out_free) begin
                    q_pop = 1'b1;
                    if (q_status == ST_OK) begin
                        state_next = B_EMIT;
                        idx_next   = '0;
                    end else begin
                        valid_next  = 1'b1;
                        status_next = q_status;
                        byte_next   = '0;
                        last_next   = 1'b1;
                    end
                end
            end
            B_EMIT: begin
                if (out_free) begin
                    valid_next  = 1'b1;
                    status_next = ST_OK;
                    byte_next   = rd_data;
                    last_next   = is_last;
                    rd_addr     = idx_inc[ADDR_W-1:0];
                    idx_next    = idx_inc;
                    if (is_last) begin
                        frame_done = 1'b1;
                        state_next = B_IDLE;
                    end
                end
            end
        endcase
    end

    // State and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
        idx_reg    <= idx_next;
        status_reg <= status_next;
        byte_reg   <= byte_next;
        last_reg   <= last_next;
    end

`ifndef SYNTHESIS
    // While a frame is read back the index stays inside the frame.
    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == B_EMIT |-> idx_reg < frame_len)
        else $error("read-back index beyond frame length");

    // The frame length is held for the whole read-back.
    a_len_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == B_EMIT && $past(state_reg) == B_EMIT |-> $stable(frame_len))
        else $error("frame length changed during read-back");
`endif

endmodule

>>> sv/header_tail_frame_parser.sv
// Header/tail frame parser, top level.
// Input channel (s_valid/s_ready/s_in_byte) takes one received byte per
// transfer. The parser hunts for the three header bytes held in the header
// register, stores the frame until the tail byte, then replays the whole
// frame, header and tail included, on the result channel (m_valid/m_ready,
// m_status/m_frame_byte/m_last) with status OK and the final byte marked.
// Every other byte gives one status result with m_last set.
// Throughput: one byte per cycle while only status results are produced,
// limited by the two-entry command queue and the output register. After a
// tail byte the input is held off until the frame store has been read back,
// one byte per cycle while the receiver is ready.
// When the receiver stalls, the output register holds its result and the
// queue fills, after which s_ready drops.
// Reset restores the header and tail registers and returns the parser to
// idle; the frame store needs no clearing. Configuration writes through
// cfg_wen/cfg_index/cfg_wdata take effect at once. They are to be made
// while idle; this binds the user, the block itself does not enforce it.
module header_tail_frame_parser #(
    parameter int MSG_MAX = 64
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [htfp_pkg::BYTE_W-1:0]      s_in_byte,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [htfp_pkg::STATUS_W-1:0]    m_status,
    output logic [htfp_pkg::BYTE_W-1:0]      m_frame_byte,
    output logic                             m_last,
    input  logic                             cfg_wen,
    input  logic [htfp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [htfp_pkg::HDR_W-1:0]       cfg_wdata
);

    import htfp_pkg::*;

    localparam int CNT_W  = $clog2(MSG_MAX + 1);
    localparam int ADDR_W = $clog2(MSG_MAX);

    logic              q_full;
    logic              q_empty;
    logic              q_push;
    logic              q_pop;
    status_t           q_push_status;
    status_t           q_head_status;
    logic              frame_done;
    logic [CNT_W-1:0]  frame_len;
    logic              mem_wen;
    logic [ADDR_W-1:0] mem_waddr;
    logic [BYTE_W-1:0] mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;
    logic [BYTE_W-1:0] mem_rdata;

    // Byte classification and storage.
    htfp_front #(
        .MSG_MAX (MSG_MAX),
        .CNT_W   (CNT_W),
        .ADDR_W  (ADDR_W)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_in_byte  (s_in_byte),
        .cfg_wen    (cfg_wen),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_status   (q_push_status),
        .frame_done (frame_done),
        .frame_len  (frame_len),
        .mem_wen    (mem_wen),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata)
    );

    // Command queue between the two halves.
    htfp_cmdq u_cmdq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .push        (q_push),
        .push_status (q_push_status),
        .pop         (q_pop),
        .empty       (q_empty),
        .full        (q_full),
        .head_status (q_head_status)
    );

    // Frame store.
    htfp_ram #(
        .WIDTH  (BYTE_W),
        .DEPTH  (MSG_MAX),
        .ADDR_W (ADDR_W)
    ) u_store (
        .aclk  (aclk),
        .wen   (mem_wen),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Result generation.
    htfp_back #(
        .MSG_MAX (MSG_MAX),
        .CNT_W   (CNT_W),
        .ADDR_W  (ADDR_W)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_empty      (q_empty),
        .q_pop        (q_pop),
        .q_status     (q_head_status),
        .frame_len    (frame_len),
        .frame_done   (frame_done),
        .rd_addr      (mem_raddr),
        .rd_data      (mem_rdata),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_frame_byte (m_frame_byte),
        .m_last       (m_last)
    );

endmodule

>>> bench/header_tail_frame_parser_tb.sv
// Self-checking testbench for the header/tail frame parser.
// Depends on htfp_pkg and header_tail_frame_parser, and through it on the other design files.
`timescale 1ns / 100ps

module header_tail_frame_parser_tb;
    import htfp_pkg::*;

    localparam int MSG_MAX     = 64;
    localparam int CYCLE_LIMIT = 2000000;

    typedef enum logic [1:0] {PH_IDLE, PH_HEADER, PH_PAYLOAD} parse_phase_t;
    typedef enum logic [1:0] {ROW_BYTE, ROW_CFG_HDR, ROW_CFG_TAIL} row_kind_t;

    typedef struct {
        status_t     status;
        logic [7:0]  fbyte;
        logic        last;
    } frame_res_t;

    typedef struct {
        row_kind_t   kind;
        logic [23:0] value;
        bit          has_exp;
        status_t     status;
    } stim_row_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic [BYTE_W-1:0]    s_in_byte;
    logic                 m_valid;
    logic                 m_ready;
    logic [STATUS_W-1:0]  m_status;
    logic [BYTE_W-1:0]    m_frame_byte;
    logic                 m_last;
    logic                 cfg_wen;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [HDR_W-1:0]     cfg_wdata;

    // Shadow of the parser: registers, phase, and the bytes of the open frame.
    logic [HDR_W-1:0]     hdr_reg;
    logic [BYTE_W-1:0]    tail_reg;
    parse_phase_t         prs_phase;
    int                   prs_count;
    int                   prs_hdr_pos;
    logic [BYTE_W-1:0]    frame_mem [MSG_MAX];

    frame_res_t           pending_results [$];
    int                   errors;
    int                   items_sent;
    int                   cycle_count;
    int                   m_stall;
    bit                   calm_s;
    bit                   calm_m;

    // Directed stimulus; rows with has_exp carry a single known status result.
    stim_row_t dir_rows [0:28] = '{
        '{ROW_BYTE,     "x",       1'b1, ST_UNDETECTED},
        '{ROW_BYTE,     24'h00,    1'b1, ST_UNDETECTED},
        '{ROW_BYTE,     "h",       1'b1, ST_PROGRESS},
        '{ROW_BYTE,     "x",       1'b1, ST_SYNC_FAIL},
        '{ROW_BYTE,     "h",       1'b1, ST_PROGRESS},
        '{ROW_BYTE,     "h",       1'b1, ST_SYNC_FAIL},
        '{ROW_BYTE,     "f",       1'b1, ST_UNDETECTED},
        '{ROW_BYTE,     "h",       1'b0, ST_PROGRESS},
        '{ROW_BYTE,     "f",       1'b0, ST_PROGRESS},
        '{ROW_BYTE,     " ",       1'b0, ST_PROGRESS},
        '{ROW_BYTE,     24'hFF,    1'b0, ST_PROGRESS},
        '{ROW_BYTE,     ";",       1'b0, ST_PROGRESS},
        '{ROW_BYTE,     "h",       1'b0, ST_PROGRESS},
        '{ROW_BYTE,     "f",       1'b0, ST_PROGRESS},
        '{ROW_BYTE,     " ",       1'b0, ST_PROGRESS},
        '{ROW_BYTE,     ";",       1'b0, ST_PROGRESS},
        '{ROW_CFG_HDR,  24'hFFFFFF, 1'b0, ST_PROGRESS},
        '{ROW_CFG_TAIL, 24'hFF,    1'b0, ST_PROGRESS},
        '{ROW_BYTE,     24'hFF,    1'b0, ST_PROGRESS},
        '{ROW_BYTE,     24'hFF,    1'b0, ST_PROGRESS},
        '{ROW_BYTE,     24'hFF,    1'b0, ST_PROGRESS},
        '{ROW_BYTE,     24'h00,    1'b0, ST_PROGRESS},
        '{ROW_BYTE,     24'hFF,    1'b0, ST_PROGRESS},
        '{ROW_CFG_HDR,  24'h000000, 1'b0, ST_PROGRESS},
        '{ROW_CFG_TAIL, 24'h00,    1'b0, ST_PROGRESS},
        '{ROW_BYTE,     24'h00,    1'b0, ST_PROGRESS},
        '{ROW_BYTE,     24'h00,    1'b0, ST_PROGRESS},
        '{ROW_BYTE,     24'h00,    1'b0, ST_PROGRESS},
        '{ROW_BYTE,     24'h00,    1'b0, ST_PROGRESS}
    };

    header_tail_frame_parser #(
        .MSG_MAX(MSG_MAX)
    ) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_in_byte(s_in_byte),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_status(m_status),
        .m_frame_byte(m_frame_byte),
        .m_last(m_last),
        .cfg_wen(cfg_wen),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    initial aclk = 1'b0;
    always #4 aclk = ~aclk;

    // Queue one status-only result.
    function automatic void note_status(input status_t st);
        pending_results.push_back('{st, 8'h00, 1'b1});
    endfunction

    // Append a byte to the open frame while there is room.
    function automatic void keep_byte(input logic [7:0] c);
        if (prs_count < MSG_MAX) begin
            frame_mem[prs_count] = c;
            prs_count++;
        end
    endfunction

    // Advance the shadow parser by one byte and queue the results it causes.
    function automatic void parse_byte(input logic [7:0] c);
        int n;
        case (prs_phase)
            PH_HEADER: begin
                if (prs_hdr_pos < HDR_LEN && c == hdr_reg[(2 - prs_hdr_pos) * 8 +: 8]) begin
                    keep_byte(c);
                    prs_hdr_pos++;
                    if (prs_hdr_pos == HDR_LEN)
                        prs_phase = PH_PAYLOAD;
                    note_status(ST_PROGRESS);
                end else begin
                    prs_phase = PH_IDLE;
                    note_status(ST_SYNC_FAIL);
                end
            end
            PH_PAYLOAD: begin
                keep_byte(c);
                if (c == tail_reg) begin
                    // The tail test wins over the length test, so a full frame is still sent.
                    n = prs_count;
                    for (int k = 0; k < n; k++)
                        pending_results.push_back('{ST_OK, frame_mem[k], k == n - 1});
                    prs_phase = PH_IDLE;
                end else if (prs_count >= MSG_MAX) begin
                    prs_phase = PH_IDLE;
                    note_status(ST_OVERFLOW);
                end else begin
                    note_status(ST_PROGRESS);
                end
            end
            default: begin
                if (c == hdr_reg[23:16]) begin
                    prs_phase   = PH_HEADER;
                    prs_count   = 0;
                    keep_byte(c);
                    prs_hdr_pos = 1;
                    note_status(ST_PROGRESS);
                end else begin
                    prs_phase = PH_IDLE;
                    note_status(ST_UNDETECTED);
                end
            end
        endcase
        if (prs_phase == PH_IDLE) begin
            prs_count   = 0;
            prs_hdr_pos = 0;
        end
    endfunction

    // Offer one byte after a random gap and record its results once transferred.
    task automatic send_byte(input logic [7:0] b, input bit has_exp, input status_t st);
        int gap;
        gap = calm_s ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid   = 1'b1;
        s_in_byte = b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        parse_byte(b);
        if (has_exp) begin
            void'(pending_results.pop_back());
            pending_results.push_back('{st, 8'h00, 1'b1});
        end
        items_sent++;
        @(negedge aclk);
    endtask

    // Hold the input until every queued result has come out, then let the pipe settle.
    task automatic drain();
        s_valid = 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [HDR_W-1:0] val);
        drain();
        cfg_wen   = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        @(negedge aclk);
        cfg_wen = 1'b0;
        if (idx == REG_HEADER)
            hdr_reg = val;
        else
            tail_reg = val[7:0];
    endtask

    // Header, payload bytes that never equal the tail, then the tail if asked.
    task automatic send_frame(input int payload_len, input bit with_tail);
        logic [7:0] b;
        for (int j = 0; j < HDR_LEN; j++)
            send_byte(hdr_reg[(2 - j) * 8 +: 8], 1'b0, ST_PROGRESS);
        for (int j = 0; j < payload_len; j++) begin
            b = 8'($urandom);
            if (b == tail_reg)
                b = b ^ 8'h01;
            send_byte(b, 1'b0, ST_PROGRESS);
        end
        if (with_tail)
            send_byte(tail_reg, 1'b0, ST_PROGRESS);
    endtask

    // Compare each result transfer with the oldest expectation.
    always @(posedge aclk) begin : check_results
        frame_res_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result status %0d byte %h last %b",
                         $time, m_status, m_frame_byte, m_last);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (m_status !== want.status) begin
                    $display("%0t: status expected %0d got %0d", $time, want.status, m_status);
                    errors++;
                end
                if (m_frame_byte !== want.fbyte) begin
                    $display("%0t: frame_byte expected %h got %h",
                             $time, want.fbyte, m_frame_byte);
                    errors++;
                end
                if (m_last !== want.last) begin
                    $display("%0t: last expected %b got %b", $time, want.last, m_last);
                    errors++;
                end
            end
            m_stall = calm_m ? 0 : $urandom_range(0, 17);
        end
    end

    // Receiver back-pressure: stall for the drawn number of cycles after each transfer.
    always @(negedge aclk) begin
        if (m_stall > 0) begin
            m_ready = 1'b0;
            m_stall--;
        end else begin
            m_ready = 1'b1;
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        int          phase_end;
        int          kind;
        int          len;
        logic [23:0] hdr_new;
        logic [7:0]  tail_new;
        logic [7:0]  b;

        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_in_byte   = '0;
        m_ready     = 1'b0;
        cfg_wen     = 1'b0;
        cfg_index   = '0;
        cfg_wdata   = '0;
        errors      = 0;
        items_sent  = 0;
        cycle_count = 0;
        m_stall     = 0;
        calm_s      = 1'b0;
        calm_m      = 1'b0;
        hdr_reg     = HDR_RESET;
        tail_reg    = TAIL_RESET;
        prs_phase   = PH_IDLE;
        prs_count   = 0;
        prs_hdr_pos = 0;

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed part.
        foreach (dir_rows[i]) begin
            case (dir_rows[i].kind)
                ROW_CFG_HDR:  write_reg(REG_HEADER, dir_rows[i].value);
                ROW_CFG_TAIL: write_reg(REG_TAIL, dir_rows[i].value);
                default:      send_byte(dir_rows[i].value[7:0], dir_rows[i].has_exp,
                                        dir_rows[i].status);
            endcase
        end

        // Random part, one register setting per phase.
        for (int ph = 0; ph < 8; ph++) begin
            // Bring the parser back to hunting before the registers change.
            if (prs_phase == PH_PAYLOAD)
                send_byte(tail_reg, 1'b0, ST_PROGRESS);
            else if (prs_phase == PH_HEADER)
                send_byte(~hdr_reg[(2 - prs_hdr_pos) * 8 +: 8], 1'b0, ST_PROGRESS);

            hdr_new  = 24'($urandom);
            tail_new = 8'($urandom);
            case (ph)
                0, 5: begin
                    hdr_new  = HDR_RESET;
                    tail_new = TAIL_RESET;
                end
                1: begin
                    hdr_new  = 24'hFFFFFF;
                    tail_new = 8'h00;
                end
                3: tail_new = hdr_new[15:8];
                4: begin
                    hdr_new  = 24'h000000;
                    tail_new = 8'hFF;
                end
                7: tail_new = hdr_new[23:16];
                default: ;
            endcase
            write_reg(REG_HEADER, hdr_new);
            write_reg(REG_TAIL, {16'h0000, tail_new});
            calm_s = (ph == 3);
            calm_m = (ph == 3 || ph == 6);

            // Overflow: the store fills without a tail.
            if (ph == 2)
                send_frame(MSG_MAX - HDR_LEN, 1'b0);
            // Tail arriving exactly at full length.
            if (ph == 5)
                send_frame(MSG_MAX - HDR_LEN - 1, 1'b1);

            phase_end = items_sent + 2;
            while (items_sent < phase_end) begin
                kind = $urandom_range(0, 9);
                if (kind < 6) begin
                    len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24)
                                                       : $urandom_range(0, 6);
                    send_frame(len, 1'b1);
                end else if (kind < 8) begin
                    // Header cut short by an arbitrary byte.
                    len = $urandom_range(1, 2);
                    for (int j = 0; j < len; j++)
                        send_byte(hdr_reg[(2 - j) * 8 +: 8], 1'b0, ST_PROGRESS);
                    b = 8'($urandom);
                    send_byte(b, 1'b0, ST_PROGRESS);
                end else begin
                    repeat ($urandom_range(1, 4)) begin
                        b = ($urandom_range(0, 3) == 0) ? hdr_reg[23:16] : 8'($urandom);
                        send_byte(b, 1'b0, ST_PROGRESS);
                    end
                end
            end
        end

        drain();
        repeat (20) @(negedge aclk);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
